// ----- rtl/amg_pkg.sv -----
// amg_pkg: shared constants, operation codes and the result record
// for the adjacency matrix graph store; no dependencies
`default_nettype none

package amg_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 8;
  localparam int VTX_BITS     = $clog2(MAX_VERTICES);
  localparam int ADDR_BITS    = 2 * VTX_BITS;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int CNT_BITS     = 5;
  localparam int OP_BITS      = 3;
  localparam int IN_BITS      = 24;
  localparam int OUT_BITS     = 16;

  localparam logic [OP_BITS-1:0] OP_ADJ = 3'd0;
  localparam logic [OP_BITS-1:0] OP_NBR = 3'd1;
  localparam logic [OP_BITS-1:0] OP_ADD = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DEL = 3'd3;
  localparam logic [OP_BITS-1:0] OP_GET = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SET = 3'd5;

  // first member is the top bit, so ok lands in bit 0
  typedef struct packed {
    logic                range_error;
    logic                neighbor_valid;
    logic [3:0]          neighbor;
    logic [7:0]          edge_weight;
    logic                ok;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/amg_ram.sv -----
// amg_ram: generic simple dual-port ram, one write and one registered read
// per cycle; read data holds while no read is issued; no dependencies
`default_nettype none

module amg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/adjacency_matrix_graph_store.sv -----
// adjacency_matrix_graph_store: symmetric weighted adjacency matrix of an undirected graph
// single-entry ops: read, check with the (a,b) write, and the mirror (b,a) write when a write is due
// neighbor listing: each row entry is read and then checked in turn, one ram read port sets the pace
// one request at a time; s_axis_tready is high only while the sequencer is idle
// reset (rst, synchronous): matrix reads as empty at once via per-entry valid bits,
// vertex_count returns to 16; depends on amg_pkg and amg_ram
`default_nettype none

module adjacency_matrix_graph_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: vertex_count
  input  wire logic                          cfg_wr_en,
  input  wire logic [amg_pkg::CNT_BITS-1:0]  cfg_wr_data,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // tdata from bit 0: op[2:0], vertex_a[6:3], vertex_b[10:7], weight[18:11], zero fill
  input  wire logic [amg_pkg::IN_BITS-1:0]   s_axis_tdata,
  // result stream
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata from bit 0: ok[0], edge_weight[8:1], neighbor[12:9], neighbor_valid[13],
  // range_error[14], zero fill[15]
  output      logic [amg_pkg::OUT_BITS-1:0]  m_axis_tdata,
  output      logic                          m_axis_tlast
);

  import amg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_WR_BA,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_END
  } state_t;

  state_t state;

  // configuration and derived vertex limit
  logic [CNT_BITS-1:0]    vertex_count;
  logic [CNT_BITS-1:0]    n_eff;

  // latched request
  logic [OP_BITS-1:0]     op;
  logic [VTX_BITS-1:0]    va;
  logic [VTX_BITS-1:0]    vb;
  logic [WEIGHT_BITS-1:0] wr_val;
  result_t                res;

  // neighbor scan
  logic [CNT_BITS-1:0]    idx;
  logic                   have_pend;
  logic [VTX_BITS-1:0]    pend;

  // entry valid bits stand in for the reset clear of the matrix
  logic [DEPTH-1:0]       vld;
  logic                   vld_q;

  // ram ports
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr;
  logic                   ram_re;
  logic [ADDR_BITS-1:0]   ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic [WEIGHT_BITS-1:0] rd_eff;
  logic                   nz;
  logic                   wr_cond;
  logic                   out_free;
  logic                   out_load;
  logic                   in_acc;

  // incoming fields
  logic [OP_BITS-1:0]     in_op;
  logic [VTX_BITS-1:0]    in_a;
  logic [VTX_BITS-1:0]    in_b;
  logic [WEIGHT_BITS-1:0] in_w;
  logic                   a_bad;
  logic                   b_bad;
  logic                   in_err;

  assign in_op = s_axis_tdata[2:0];
  assign in_a  = s_axis_tdata[6:3];
  assign in_b  = s_axis_tdata[10:7];
  assign in_w  = s_axis_tdata[18:11];

  // counts above the matrix size saturate
  assign n_eff = (vertex_count > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
                                                           : vertex_count;
  assign a_bad = ({1'b0, in_a} >= n_eff);
  assign b_bad = ({1'b0, in_b} >= n_eff);
  // listing checks only vertex_a, spare ops check nothing
  assign in_err = (in_op == OP_NBR) ? a_bad : ((in_op <= OP_SET) && (a_bad || b_bad));

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // a new result transaction is loaded this cycle
  assign out_load      = out_free && ((state == S_EMIT) || (state == S_SCAN_END) ||
                                      ((state == S_SCAN_CHK) && nz && have_pend));

  // an entry never written since reset reads as no edge
  assign rd_eff = vld_q ? ram_rdata : '0;
  assign nz     = |rd_eff;

  // add writes only when absent, delete only when present, set always
  assign wr_cond = ((op == OP_ADD) && !nz) || ((op == OP_DEL) && nz) || (op == OP_SET);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {va, vb};
    ram_we    = 1'b0;
    ram_waddr = {va, vb};
    unique case (state)
      S_RD: begin
        ram_re = 1'b1;
      end
      S_SCAN_RD: begin
        ram_re    = (idx != n_eff);
        ram_raddr = {va, idx[VTX_BITS-1:0]};
      end
      S_CHK: begin
        ram_we = wr_cond;
      end
      S_WR_BA: begin
        ram_we    = 1'b1;
        ram_waddr = {vb, va};
      end
      default: begin
      end
    endcase
  end

  amg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= CNT_BITS'(16);
      vld           <= '0;
      have_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_q <= vld[ram_raddr];
      end
      // result transaction taken downstream
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op     <= in_op;
            va     <= in_a;
            vb     <= in_b;
            wr_val <= (in_op == OP_DEL) ? '0 : in_w;
            res    <= result_t'{range_error: in_err, neighbor_valid: 1'b0, neighbor: '0,
                                edge_weight: '0, ok: 1'b0};
            idx    <= '0;
            have_pend <= 1'b0;
            if ((in_op > OP_SET) || in_err) begin
              state <= S_EMIT;
            end else if (in_op == OP_NBR) begin
              state <= S_SCAN_RD;
            end else begin
              state <= S_RD;
            end
          end
        end

        S_RD: begin
          state <= S_CHK;
        end

        // read data of entry (a,b) is ready here; write (a,b) if needed
        S_CHK: begin
          unique case (op) inside
            OP_ADJ: res.ok <= nz;
            OP_ADD, OP_DEL: res.ok <= wr_cond;
            OP_GET: res.edge_weight <= rd_eff;
            default: begin
            end
          endcase
          state <= wr_cond ? S_WR_BA : S_EMIT;
        end

        // mirror write to (b,a)
        S_WR_BA: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, res};
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_SCAN_RD: begin
          state <= (idx == n_eff) ? S_SCAN_END : S_SCAN_CHK;
        end

        // an empty entry moves on; a neighbor found is held, and the one held before it goes out without the last mark
        S_SCAN_CHK: begin
          if (!nz) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end else if (!have_pend) begin
            have_pend <= 1'b1;
            pend      <= idx[VTX_BITS-1:0];
            idx       <= idx + 1'b1;
            state     <= S_SCAN_RD;
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, result_t'{range_error: 1'b0, neighbor_valid: 1'b1,
                                              neighbor: pend, edge_weight: '0, ok: 1'b0}};
            m_axis_tlast  <= 1'b0;
            pend          <= idx[VTX_BITS-1:0];
            idx           <= idx + 1'b1;
            state         <= S_SCAN_RD;
          end
        end

        // final result: held neighbor with the last mark, or an empty result
        S_SCAN_END: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, result_t'{range_error: 1'b0, neighbor_valid: have_pend,
                                              neighbor: have_pend ? pend : '0,
                                              edge_weight: '0, ok: 1'b0}};
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
